// File: hdl/stunv_pkg.sv
`timescale 1ns / 1ps

package stunv_pkg;

    localparam int unsigned COUNT_W    = 17;
    localparam int unsigned LENGTH_W   = 16;
    localparam int unsigned STATUS_W   = 2;

    localparam logic [COUNT_W-1:0] HEADER_BYTES      = 17'd20;
    localparam logic [COUNT_W-1:0] ATTR_HEADER_BYTES = 17'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 17'h1FFFF;
    localparam logic [COUNT_W-1:0] LEN_HI_OFFSET     = 17'd2;
    localparam logic [COUNT_W-1:0] LEN_LO_OFFSET     = 17'd3;

    typedef enum logic [1:0] {
        PHASE_TYPE_HI = 2'd0,
        PHASE_TYPE_LO = 2'd1,
        PHASE_LEN_HI  = 2'd2,
        PHASE_LEN_LO  = 2'd3
    } attr_phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_OVERRUN  = 2'd3
    } status_t;

endpackage

// File: hdl/stunv_walk.sv
`timescale 1ns / 1ps

module stunv_walk
    import stunv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] data_byte,
    input  logic       last,
    output status_t    status
);

    logic [COUNT_W-1:0]  byte_count_reg,         byte_count_next;
    logic [LENGTH_W-1:0] message_length_reg,     message_length_next;
    logic [COUNT_W-1:0]  next_header_offset_reg, next_header_offset_next;
    logic [LENGTH_W-1:0] attribute_length_reg,   attribute_length_next;
    attr_phase_t         attribute_phase_reg,    attribute_phase_next;
    logic                overrun_seen_reg,       overrun_seen_next;

    logic [COUNT_W-1:0]  total;
    logic [COUNT_W:0]    expected_idx;
    logic                walk_en;
    logic [LENGTH_W-1:0] attr_len_full;
    logic [COUNT_W-1:0]  remaining;
    logic [1:0]          pad;

    // stepped values, before the end-of-packet clear
    logic [COUNT_W-1:0]  bc_step, nho_step;
    logic [LENGTH_W-1:0] ml_step, al_step;
    attr_phase_t         ph_step;
    logic                ovr_step;

    always_comb
    begin
        ml_step = message_length_reg;
        if (byte_count_reg == LEN_HI_OFFSET)
        begin
            ml_step = {data_byte, 8'h00};
        end
        else if (byte_count_reg == LEN_LO_OFFSET)
        begin
            ml_step = {message_length_reg[15:8], data_byte};
        end

        total         = HEADER_BYTES + {1'b0, ml_step};
        expected_idx  = {1'b0, next_header_offset_reg}
                      + {{(COUNT_W - 1){1'b0}}, attribute_phase_reg};
        walk_en       = (byte_count_reg >= HEADER_BYTES) && (byte_count_reg < total)
                      && !overrun_seen_reg && ({1'b0, byte_count_reg} == expected_idx);
        attr_len_full = {attribute_length_reg[15:8], data_byte};
        remaining     = total - next_header_offset_reg - ATTR_HEADER_BYTES;
        pad           = 2'(~attr_len_full[1:0] + 2'd1);

        nho_step = next_header_offset_reg;
        al_step  = attribute_length_reg;
        ph_step  = attribute_phase_reg;
        ovr_step = overrun_seen_reg;
        if (walk_en)
        begin
            case (attribute_phase_reg)
                PHASE_LEN_HI:
                begin
                    al_step = {data_byte, 8'h00};
                    ph_step = PHASE_LEN_LO;
                end
                PHASE_LEN_LO:
                begin
                    al_step = attr_len_full;
                    ph_step = PHASE_TYPE_HI;
                    if ({1'b0, attr_len_full} > remaining)
                    begin
                        ovr_step = 1'b1;
                    end
                    else
                    begin
                        nho_step = next_header_offset_reg + ATTR_HEADER_BYTES
                                 + {1'b0, attr_len_full}
                                 + {{(COUNT_W - 2){1'b0}}, pad};
                    end
                end
                PHASE_TYPE_LO:
                begin
                    ph_step = PHASE_LEN_HI;
                end
                default:
                begin
                    ph_step = PHASE_TYPE_LO;
                end
            endcase
        end

        bc_step = (byte_count_reg < COUNT_MAX) ? byte_count_reg + 17'd1 : byte_count_reg;

        if (bc_step < HEADER_BYTES)
        begin
            status = ST_SHORT;
        end
        else if (bc_step != total)
        begin
            status = ST_MISMATCH;
        end
        else if (ovr_step)
        begin
            status = ST_OVERRUN;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        byte_count_next         = byte_count_reg;
        message_length_next     = message_length_reg;
        next_header_offset_next = next_header_offset_reg;
        attribute_length_next   = attribute_length_reg;
        attribute_phase_next    = attribute_phase_reg;
        overrun_seen_next       = overrun_seen_reg;
        if (byte_valid)
        begin
            if (last)
            begin
                byte_count_next         = '0;
                message_length_next     = '0;
                next_header_offset_next = HEADER_BYTES;
                attribute_length_next   = '0;
                attribute_phase_next    = PHASE_TYPE_HI;
                overrun_seen_next       = 1'b0;
            end
            else
            begin
                byte_count_next         = bc_step;
                message_length_next     = ml_step;
                next_header_offset_next = nho_step;
                attribute_length_next   = al_step;
                attribute_phase_next    = ph_step;
                overrun_seen_next       = ovr_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg         <= '0;
            message_length_reg     <= '0;
            next_header_offset_reg <= HEADER_BYTES;
            attribute_length_reg   <= '0;
            attribute_phase_reg    <= PHASE_TYPE_HI;
            overrun_seen_reg       <= 1'b0;
        end
        else
        begin
            byte_count_reg         <= byte_count_next;
            message_length_reg     <= message_length_next;
            next_header_offset_reg <= next_header_offset_next;
            attribute_length_reg   <= attribute_length_next;
            attribute_phase_reg    <= attribute_phase_next;
            overrun_seen_reg       <= overrun_seen_next;
        end
    end

endmodule

// File: hdl/stun_packet_validator_core.sv
`timescale 1ns / 1ps
// The status of a packet is registered and is valid on m_tvalid in the cycle after its last byte is taken.
// Throughput: one byte per cycle while s_tready is high; the parse state updates on every accepted byte.
// s_tready drops only while a status waits in the output register and m_tready is low.
// Reset (rst_n, asynchronous, active low) empties the output register and returns
// the parse state to the start of a packet.

module stun_packet_validator_core
    import stunv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // slave side: one packet byte per transaction
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last byte of the packet
    // master side: one status per packet
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] status, [7:2] zero
);

    logic    s_accept;
    status_t walk_status;

    logic    m_valid_reg, m_valid_next;
    status_t status_reg,  status_next;

    // Take a byte whenever the output register is empty or draining this cycle.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Byte counter, length capture and attribute walk.
    stunv_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_accept),
        .data_byte  (s_tdata),
        .last       (s_tlast),
        .status     (walk_status)
    );

    // Output register: load the status on the last byte, drop it once taken.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        if (s_accept && s_tlast)
        begin
            m_valid_next = 1'b1;
            status_next  = walk_status;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            status_reg  <= ST_OK;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - STATUS_W){1'b0}}, status_reg};

endmodule

// File: verif/stun_packet_validator_core_tb.sv
`timescale 1ns / 1ps

module stun_packet_validator_core_tb;
    import stunv_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold;   // wait for every pending status before sending this byte
    } pkt_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    stun_packet_validator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    pkt_byte_t   byte_queue[$];
    logic [7:0]  frame_bytes[$];
    status_t     status_due[$];
    status_t     want;
    pkt_byte_t   head_byte;
    int          errors = 0;
    int          bytes_planned = 0;
    int          bytes_taken = 0;
    int          status_hits[4] = '{0, 0, 0, 0};
    logic        byte_taken = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned rdy_mode = 0;
    int unsigned rdy_span = 0;

    // Parser state mirrored from the spec of the block
    logic [COUNT_W-1:0]  rx_count;
    logic [LENGTH_W-1:0] msg_len;
    logic [COUNT_W-1:0]  hdr_at;
    logic [LENGTH_W-1:0] attr_len;
    attr_phase_t         phase;
    bit                  overrun;

    task automatic restart_parse();
        rx_count = '0;
        msg_len  = '0;
        hdr_at   = HEADER_BYTES;
        attr_len = '0;
        phase    = PHASE_TYPE_HI;
        overrun  = 1'b0;
    endtask

    // Advance the parser by one accepted byte; queue a status on the last byte.
    task automatic track_byte(input logic [7:0] b, input logic is_last);
        logic [COUNT_W-1:0] idx;
        logic [COUNT_W:0]   total;
        logic [COUNT_W:0]   room;
        logic [COUNT_W:0]   next_at;
        logic [1:0]         pad;
        status_t            st;
        idx = rx_count;
        if (idx == LEN_HI_OFFSET)
            msg_len = {b, 8'h00};
        else if (idx == LEN_LO_OFFSET)
            msg_len[7:0] = b;
        total = (COUNT_W+1)'(HEADER_BYTES) + (COUNT_W+1)'(msg_len);

        // Only the byte at the current header position moves the walk
        if (idx >= HEADER_BYTES && (COUNT_W+1)'(idx) < total && !overrun
            && (COUNT_W+1)'(idx) == (COUNT_W+1)'(hdr_at) + (COUNT_W+1)'(phase)) begin
            case (phase)
                PHASE_TYPE_HI: phase = PHASE_TYPE_LO;
                PHASE_TYPE_LO: phase = PHASE_LEN_HI;
                PHASE_LEN_HI:
                begin
                    attr_len = {b, 8'h00};
                    phase    = PHASE_LEN_LO;
                end
                default:
                begin
                    attr_len[7:0] = b;
                    room = total - (COUNT_W+1)'(hdr_at) - (COUNT_W+1)'(ATTR_HEADER_BYTES);
                    if ((COUNT_W+1)'(attr_len) > room)
                        overrun = 1'b1;
                    else begin
                        pad     = 2'd0 - attr_len[1:0];
                        next_at = (COUNT_W+1)'(hdr_at) + (COUNT_W+1)'(ATTR_HEADER_BYTES)
                                  + (COUNT_W+1)'(attr_len) + (COUNT_W+1)'(pad);
                        hdr_at  = next_at[COUNT_W-1:0];
                    end
                    phase = PHASE_TYPE_HI;
                end
            endcase
        end

        if (rx_count != COUNT_MAX)
            rx_count = rx_count + 1'b1;

        if (is_last) begin
            if (rx_count < HEADER_BYTES)
                st = ST_SHORT;
            else if (rx_count != HEADER_BYTES + COUNT_W'(msg_len))
                st = ST_MISMATCH;
            else if (overrun)
                st = ST_OVERRUN;
            else
                st = ST_OK;
            status_due.push_back(st);
            status_hits[int'(st)]++;
            restart_parse();
        end
    endtask

    // Frame assembly helpers
    task automatic open_frame();
        frame_bytes.delete();
        repeat (20) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic put_bytes(input int n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic put_attr(input int len, input bit padded);
        put_bytes(2);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        put_bytes(len);
        if (padded)
            put_bytes((4 - len % 4) % 4);
    endtask

    task automatic put_attr_run();
        int n;
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
            put_attr($urandom_range(0, 20), (i != n - 1) || ($urandom_range(0, 3) != 0));
        if ($urandom_range(0, 3) == 0)
            put_bytes($urandom_range(1, 3));
    endtask

    task automatic seal_length(input int len);
        frame_bytes[2] = len[15:8];
        frame_bytes[3] = len[7:0];
    endtask

    task automatic ship_frame(input bit hold);
        pkt_byte_t pb;
        foreach (frame_bytes[i]) begin
            pb.data = frame_bytes[i];
            pb.last = (i == frame_bytes.size() - 1);
            pb.hold = hold && (i == 0);
            byte_queue.push_back(pb);
        end
        bytes_planned += frame_bytes.size();
    endtask

    // Sender: bursts of random length separated by short random gaps
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !byte_taken) begin
            // hold the current transaction until it is taken
        end
        else if (gap_left != 0) begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (byte_queue.size() != 0
                 && !(byte_queue[0].hold && status_due.size() != 0)) begin
            head_byte = byte_queue.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= head_byte.data;
            s_tlast  <= head_byte.last;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 48);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
            end
            else
                burst_left <= burst_left - 1;
        end
        else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: switch between always ready, coin flip, mostly stalled and a fixed pattern
    always @(negedge clk) begin
        if (rdy_span == 0) begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_span <= $urandom_range(50, 400);
        end
        else
            rdy_span <= rdy_span - 1;
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (rdy_span % 5) < 2;
        endcase
    end

    // Monitor: check the status stream first, then predict from the byte stream
    always @(posedge clk) begin
        if (!rst_n) begin
            byte_taken <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (status_due.size() == 0) begin
                    $error("status: no status expected, got %0d", m_tdata[1:0]);
                    errors++;
                end
                else begin
                    want = status_due.pop_front();
                    if (m_tdata[1:0] !== want) begin
                        $error("status: expected %0d, got %0d", want, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        $error("tdata[7:2]: expected 0, got %0d", m_tdata[7:2]);
                        errors++;
                    end
                end
            end
            byte_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                track_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
        end
    end

    initial begin
        int pick;
        int pos;
        int m;
        int len;
        int frames;
        restart_parse();

        // Directed frames
        frame_bytes.delete();                       // single byte
        frame_bytes.push_back(8'h00);
        ship_frame(0);
        frame_bytes.delete();                       // one byte short of a header
        repeat (19) frame_bytes.push_back(8'hFF);
        ship_frame(0);
        open_frame();                               // bare header
        seal_length(0);
        ship_frame(0);
        open_frame();                               // declared body missing
        seal_length(4);
        ship_frame(0);
        open_frame();                               // bytes past the declared end
        seal_length(0);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'hFF);
        ship_frame(0);
        open_frame();                               // attribute fills the body exactly
        put_attr(4, 1);
        seal_length(8);
        ship_frame(0);
        open_frame();                               // largest attribute length
        put_bytes(2);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'hFF);
        put_bytes(4);
        seal_length(8);
        ship_frame(0);
        open_frame();                               // padded attributes
        put_attr(1, 1);
        put_attr(2, 1);
        seal_length(16);
        ship_frame(1);
        open_frame();                               // pad runs past the declared end
        put_attr(1, 0);
        seal_length(5);
        ship_frame(0);
        open_frame();                               // trailing fragment
        put_attr(4, 1);
        put_bytes(3);
        seal_length(11);
        ship_frame(0);
        open_frame();                               // overrun, then a well-formed header
        put_bytes(2);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h09);
        put_bytes(4);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        seal_length(12);
        ship_frame(0);
        open_frame();                               // largest message length, body cut short
        put_bytes(2);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'hFB);
        put_bytes(4);
        seal_length(65535);
        ship_frame(1);

        // Random frames: mostly well-formed, some broken, some noise
        frames = 0;
        while (bytes_planned < 1900 || frames < 48) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                open_frame();
                put_attr_run();
                seal_length(frame_bytes.size() - 20);
            end
            else if (pick < 70) begin
                open_frame();
                repeat ($urandom_range(0, 2)) put_attr($urandom_range(0, 12), 1);
                put_bytes(2);
                pos = frame_bytes.size();
                put_bytes(2);
                m = $urandom_range(0, 12);
                put_bytes(m);
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(m + 1, 65535);
                else
                    len = m + $urandom_range(0, 3);     // zero: exact fit, no overrun
                frame_bytes[pos]     = len[15:8];
                frame_bytes[pos + 1] = len[7:0];
                seal_length(frame_bytes.size() - 20);
            end
            else if (pick < 85) begin
                open_frame();
                put_attr_run();
                len = $urandom_range(1, 8);
                seal_length(frame_bytes.size() - 20 + ($urandom_range(0, 1) ? len : -len));
            end
            else if (pick < 93) begin
                frame_bytes.delete();
                put_bytes($urandom_range(1, 19));
            end
            else begin
                frame_bytes.delete();
                put_bytes($urandom_range(1, 60));
            end
            ship_frame((frames == 0) || ($urandom_range(0, 9) == 0));
            frames++;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (bytes_taken == bytes_planned && status_due.size() == 0);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes in %0d directed and %0d random frames;", bytes_planned,
                 12, frames);
        $display("statuses ok %0d, short %0d, mismatch %0d, overrun %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
